>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the Hamiltonian cycle engine.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held
`define GMHE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Clocked implication, antecedent and consequent in the same cycle
`define GMHE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Clocked implication, consequent checked in the next cycle
`define GMHE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gmhe_pkg.sv
// Package of the Hamiltonian cycle engine: sizes, command codes, matrix command struct.
// Used by gmhe_adj_store and graph_matrix_hamiltonian_engine; no dependencies.
`default_nettype none

package gmhe_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VTX_W        = 4;   // vertex index width
	localparam int CNT_W        = 5;   // holds 0..MAX_VERTICES

	typedef logic [VTX_W-1:0]        vtx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [MAX_VERTICES-1:0] row_t;

	// input word kinds
	typedef enum logic [1:0] {
		KIND_DIR    = 2'd0,
		KIND_BOTH   = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// command from the sequencer to the adjacency store
	typedef struct packed {
		logic wr_en;   // add edge from_v -> to_v
		logic both;    // also add to_v -> from_v
		vtx_t from_v;
		vtx_t to_v;
		logic clear;   // wipe the whole matrix
	} adj_cmd_t;

	// bits 0..n-1 set
	function automatic row_t low_mask(input cnt_t n);
		row_t m;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

	// bits at or above s set
	function automatic row_t from_mask(input cnt_t s);
		row_t m;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			m[i] = (CNT_W'(i) >= s);
		end
		return m;
	endfunction

	// index of the lowest set bit, 0 when none
	function automatic vtx_t lowest_bit(input row_t v);
		vtx_t idx;
		idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (v[i]) idx = VTX_W'(i);
		end
		return idx;
	endfunction

	function automatic row_t one_hot(input vtx_t v);
		return row_t'(1) << v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/gmhe_adj_store.sv
// Bit adjacency matrix of the Hamiltonian cycle engine: edge writes, clear, one row read.
// Depends on gmhe_pkg.
`default_nettype none

module gmhe_adj_store (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire gmhe_pkg::adj_cmd_t cmd,
	input  wire gmhe_pkg::cnt_t    n_eff,
	input  wire gmhe_pkg::vtx_t    rd_row,
	output gmhe_pkg::row_t         rd_data
);
	import gmhe_pkg::*;

	row_t rows_q [MAX_VERTICES];

	// edge is kept only when both ends are inside the graph in use
	logic ends_ok;
	assign ends_ok = ({1'b0, cmd.from_v} < n_eff) && ({1'b0, cmd.to_v} < n_eff);

	// matrix rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_VERTICES; r++) rows_q[r] <= '0;
		end else if (cmd.clear) begin
			for (int r = 0; r < MAX_VERTICES; r++) rows_q[r] <= '0;
		end else if (cmd.wr_en && ends_ok) begin
			if (cmd.both && (cmd.from_v != cmd.to_v)) begin
				rows_q[cmd.from_v] <= rows_q[cmd.from_v] | one_hot(cmd.to_v);
				rows_q[cmd.to_v]   <= rows_q[cmd.to_v] | one_hot(cmd.from_v);
			end else begin
				rows_q[cmd.from_v] <= rows_q[cmd.from_v] | one_hot(cmd.to_v);
			end
		end
	end

	// single read port
	assign rd_data = rows_q[rd_row];

endmodule

`default_nettype wire

>>> rtl/graph_matrix_hamiltonian_engine.sv
// Top level of the Hamiltonian cycle engine: sequencer, path stack, result register.
// Depends on gmhe_pkg, gmhe_adj_store and assert_macros.svh.
// An edge word (kind 0 or 1) is written to the matrix and yields no result; kind 3 is dropped.
// A search word first scans the matrix rows 0..n-1 for the universal-sink and
// odd-degree flags, then makes one push or pop per step of the backtracking search
// and then the closing-edge or empty-stack decision, then n+1 result words (cycle
// found) or one (not found) at one per cycle when out_ready stays high. All of it goes
// through the single row read port of the matrix, so the search time grows with the
// number of backtracking steps and is data dependent. The input is not ready from the
// search word until its last result word is loaded. The matrix is cleared when the
// search ends. vertex_count 0 acts as 1, above 16 as 16.
`default_nettype none

module graph_matrix_hamiltonian_engine (
	input  wire                  clk,
	input  wire                  arst_n,
	// input words
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [1:0]            kind,
	input  wire [3:0]            from_vertex,
	input  wire [3:0]            to_vertex,
	// result words
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [3:0]           vertex,
	output logic                 found,
	output logic                 sink_exists,
	output logic                 euler_possible,
	output logic                 last,
	// vertex_count register
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [4:0]            cfg_data
);
	import gmhe_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FLAGS  = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t   state_q;
	cnt_t     vcount_q;
	cnt_t     n_eff;
	row_t     nmask;

	cnt_t     cnt_q;        // row index in the scan, word index in the output
	cnt_t     odd_q;
	row_t     col_q;        // column c set while every other row has bit c
	logic     seen_q;       // an empty row has been found
	vtx_t     sink_row_q;
	logic     sink_q;
	logic     euler_q;

	vtx_t     path_q [MAX_VERTICES];
	row_t     used_q;
	cnt_t     depth_q;
	cnt_t     start_q;
	logic     found_q;

	logic     out_valid_q;
	vtx_t     vertex_q;
	logic     found_out_q;
	logic     sink_out_q;
	logic     euler_out_q;
	logic     last_q;

	adj_cmd_t adj_cmd;
	vtx_t     rd_row;
	row_t     rd_data;

	// register write port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= CNT_W'(MAX_VERTICES);
		else if (cfg_valid) vcount_q <= cfg_data;
	end

	// clamp vertex_count to 1..MAX_VERTICES
	always_comb begin
		if (vcount_q == '0) n_eff = CNT_W'(1);
		else if (vcount_q > CNT_W'(MAX_VERTICES)) n_eff = CNT_W'(MAX_VERTICES);
		else n_eff = vcount_q;
	end
	assign nmask = low_mask(n_eff);

	assign in_ready = (state_q == ST_IDLE);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// path stack read address: top of stack in search, word index in output
	cnt_t depth_m1;
	vtx_t path_rd_idx;
	vtx_t path_rd;
	assign depth_m1    = depth_q - CNT_W'(1);
	assign path_rd_idx = (state_q == ST_EMIT) ? cnt_q[VTX_W-1:0] : depth_m1[VTX_W-1:0];
	assign path_rd     = path_q[path_rd_idx];

	// shared row read: scan row in the flag pass, top of path in the search
	assign rd_row = (state_q == ST_FLAGS) ? cnt_q[VTX_W-1:0] : path_rd;

	// flag pass step
	row_t row_m;
	cnt_t odd_nx;
	row_t col_nx;
	logic seen_nx;
	vtx_t sink_row_nx;
	logic scan_end;
	always_comb begin
		row_m       = rd_data & nmask;
		odd_nx      = odd_q + CNT_W'(^row_m);
		col_nx      = col_q & (rd_data | one_hot(cnt_q[VTX_W-1:0]));
		seen_nx     = seen_q;
		sink_row_nx = sink_row_q;
		if (!seen_q && (row_m == '0)) begin
			seen_nx     = 1'b1;
			sink_row_nx = cnt_q[VTX_W-1:0];
		end
		scan_end = (cnt_q == depth_m1 + n_eff - depth_q) ;
	end

	// search step: candidates at or above start that are adjacent and unused
	row_t cand;
	logic has_cand;
	vtx_t pick;
	logic at_full;
	always_comb begin
		cand     = rd_data & ~used_q & nmask & from_mask(start_q);
		has_cand = |cand;
		pick     = lowest_bit(cand);
		at_full  = (depth_q == n_eff);
	end

	// output word of the current index
	logic out_load;
	logic out_last_nx;
	vtx_t out_vtx_nx;
	always_comb begin
		out_load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		out_last_nx = !found_q || (cnt_q == n_eff);
		out_vtx_nx  = (found_q && (cnt_q != n_eff)) ? path_rd : '0;
	end

	logic search_done;
	assign search_done = (state_q == ST_SEARCH) &&
		((at_full && rd_data[0]) || (!(at_full ? 1'b0 : has_cand) && depth_q <= CNT_W'(1)));

	// adjacency store command
	always_comb begin
		adj_cmd        = '0;
		adj_cmd.wr_en  = in_acc && ((kind == KIND_DIR) || (kind == KIND_BOTH));
		adj_cmd.both   = (kind == KIND_BOTH);
		adj_cmd.from_v = from_vertex;
		adj_cmd.to_v   = to_vertex;
		adj_cmd.clear  = search_done;
	end

	gmhe_adj_store u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (adj_cmd),
		.n_eff   (n_eff),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			odd_q      <= '0;
			col_q      <= '1;
			seen_q     <= 1'b0;
			sink_row_q <= '0;
			sink_q     <= 1'b0;
			euler_q    <= 1'b0;
			used_q     <= '0;
			depth_q    <= '0;
			start_q    <= '0;
			found_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (kind == KIND_SEARCH)) begin
						cnt_q   <= '0;
						odd_q   <= '0;
						col_q   <= '1;
						seen_q  <= 1'b0;
						state_q <= ST_FLAGS;
					end
				end
				ST_FLAGS: begin
					odd_q      <= odd_nx;
					col_q      <= col_nx;
					seen_q     <= seen_nx;
					sink_row_q <= sink_row_nx;
					cnt_q      <= cnt_q + CNT_W'(1);
					if (scan_end) begin
						sink_q  <= seen_nx && col_nx[sink_row_nx];
						euler_q <= (odd_nx == CNT_W'(0)) || (odd_nx == CNT_W'(2));
						used_q  <= row_t'(1);
						depth_q <= CNT_W'(1);
						start_q <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (!at_full && has_cand) begin
						// push
						used_q  <= used_q | one_hot(pick);
						depth_q <= depth_q + CNT_W'(1);
						start_q <= '0;
					end else if (at_full && rd_data[0]) begin
						found_q <= 1'b1;
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else if (depth_q <= CNT_W'(1)) begin
						found_q <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						// pop
						used_q  <= used_q & ~one_hot(path_rd);
						start_q <= {1'b0, path_rd} + CNT_W'(1);
						depth_q <= depth_m1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (out_last_nx) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// path stack, start vertex is always 0
	always_ff @(posedge clk) begin
		if (state_q == ST_FLAGS && scan_end) begin
			path_q[0] <= '0;
		end else if (state_q == ST_SEARCH && !at_full && has_cand) begin
			path_q[depth_q[VTX_W-1:0]] <= pick;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			vertex_q    <= out_vtx_nx;
			found_out_q <= found_q;
			sink_out_q  <= sink_q;
			euler_out_q <= euler_q;
			last_q      <= out_last_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign vertex         = vertex_q;
	assign found          = found_out_q;
	assign sink_exists    = sink_out_q;
	assign euler_possible = euler_out_q;
	assign last           = last_q;

	// checks
	`GMHE_ASSERT_IMPL(a_used_depth, state_q == ST_SEARCH,
		$countones(used_q) == 32'(depth_q), "used mask and path depth disagree")
	`GMHE_ASSERT(a_depth_bound, (state_q != ST_SEARCH) ||
		((depth_q >= CNT_W'(1)) && (depth_q <= n_eff)), "path depth out of range")
	`GMHE_ASSERT_NEXT(a_emit_end, out_load && out_last_nx,
		(state_q == ST_IDLE) && out_valid_q && last_q, "final word not flagged last")

endmodule

`default_nettype wire
